@@ src/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// Types and constants shared by the lane cooldown allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    // request codes
    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_SEEK  = 1'b1;

    // configuration register indexes
    localparam logic [7:0] CFG_LANE_COUNT = 8'd0;
    localparam logic [7:0] CFG_RATE_Q8    = 8'd1;

    // register reset values
    localparam logic [6:0] LANE_COUNT_RESET = 7'd1;
    localparam logic [9:0] RATE_Q8_RESET    = 10'd256;

    // cooldown arithmetic
    localparam int unsigned GAP_PX      = 20;
    localparam int unsigned RATE_MIN    = 128;
    localparam int unsigned RATE_MAX    = 768;
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned Q8_ONE      = 256;
    localparam int unsigned SCALED_MS   = 256000;   // ms per second in Q8

    localparam int SPAN_W    = 13;  // width_px + gap
    localparam int D_W       = 18;  // speed * rate
    localparam int N_W       = 31;  // span * 256000
    localparam int NUM_W     = 32;  // 2n + d
    localparam int DEN_W     = 19;  // 2d
    localparam int ALT_W     = 22;  // span * 1000
    localparam int CD_W      = 32;  // cooldown as computed
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = 6;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CURSOR_MOD,
        ST_PREP,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } lca_state_t;

    // request payload
    typedef struct packed {
        logic        func;
        logic [39:0] now_ms;
        logic [11:0] width_px;
        logic [7:0]  speed_px_s;
    } in_item_t;

    // result payload
    typedef struct packed {
        logic [5:0]  lane_index;
        logic        was_forced;
        logic [39:0] wait_ms;
        logic [39:0] cooldown_ms;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/lane_cooldown_allocator_core.sv @@
// ----------------------------------------------------------------------------
// lane_cooldown_allocator_core
// Picks a lane for each placed item and charges it with a cooldown.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry requests: place an item or seek.
//   out_valid/out_stall/out_data carry one result per place request; a seek
//   clears every lane and the cursor and gives no result.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write lane_count (0) and
//   rate_q8 (1); other indexes are ignored.
// Operation:
//   in a place request the lane scan through the free-time memory runs
//   beside the 32-step serial divider for the cooldown, and the lane is
//   charged only when both are done.
//   One request is worked at a time; a finished result sits in the output
//   register while the next request is accepted and worked.
//   A lane_count write holds cfg_ready low while the cursor is reduced to
//   the new count.
// Reset: all lanes free at time zero, cursor zero, lane_count 1, rate 256.
// Stall: a result held by out_stall stays in the output register; the next
//   result waits in the core until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_cooldown_allocator_core #(
    parameter int MAX_LANES = 64,
    parameter int TIME_BITS = 40
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire  lca_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire                     out_stall,
    output lca_pkg::out_item_t      out_data,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [7:0]              cfg_index,
    input  wire  [9:0]              cfg_data
);

    import lca_pkg::*;

    localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int CNT_W  = $clog2(MAX_LANES + 1);
    localparam int SUM_W  = ((TIME_BITS > CD_W) ? TIME_BITS : CD_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // lane count register clamped to 1..MAX_LANES
    function automatic logic [CNT_W-1:0] lanes_of(input logic [6:0] v);
        if (v == 7'd0)
            return CNT_W'(1);
        if (int'(v) > MAX_LANES)
            return CNT_W'(MAX_LANES);
        return CNT_W'(v);
    endfunction

    // control state
    lca_state_t           state_reg, state_next;
    logic [LANE_W-1:0]    cursor_reg;
    logic [6:0]           count_reg;
    logic [9:0]           rate_reg;
    logic [MAX_LANES-1:0] lane_vld_reg;
    logic                 out_valid_reg;

    // request payload
    logic [TIME_BITS-1:0] now_reg;
    logic [11:0]          width_reg;
    logic [7:0]           speed_reg;

    // cooldown datapath
    logic [SPAN_W-1:0]    span_reg;
    logic [D_W-1:0]       d_reg;
    logic [ALT_W-1:0]     alt_reg;
    logic                 small_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [NUM_W-1:0]     quot_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // scan datapath
    logic [LANE_W-1:0]    iss_lane_reg;
    logic [CNT_W-1:0]     iss_cnt_reg;
    logic [CNT_W-1:0]     proc_cnt_reg;
    logic                 rd_vld_reg;
    logic [LANE_W-1:0]    rd_lane_reg;
    logic                 rd_bit_reg;
    logic                 found_reg;
    logic [LANE_W-1:0]    free_lane_reg;
    logic [TIME_BITS-1:0] free_time_reg;
    logic [LANE_W-1:0]    best_lane_reg;
    logic [TIME_BITS-1:0] best_reg;

    // result staging and output register
    out_item_t            res_reg;
    out_item_t            out_data_reg;

    // free-time memory
    logic [TIME_BITS-1:0] mem [MAX_LANES];
    logic [TIME_BITS-1:0] mem_q;
    logic                 mem_we;
    logic [LANE_W-1:0]    mem_waddr;
    logic [TIME_BITS-1:0] mem_wdata;

    logic [CNT_W-1:0]     lanes;
    logic                 in_acc;
    logic                 cfg_acc;
    logic                 out_acc;
    logic                 issue;
    logic                 scan_done;
    logic                 div_done;
    logic [TIME_BITS-1:0] rd_time;
    logic [LANE_W:0]      rem_sh;
    logic                 rem_ge;
    logic [LANE_W-1:0]    sel_lane;
    logic [TIME_BITS-1:0] sel_time;
    logic [TIME_BITS-1:0] base_time;
    logic [CD_W-1:0]      cd_raw;
    logic [CD_W-1:0]      cd;
    logic [SUM_W-1:0]     sum;
    logic [LANE_W-1:0]    lane_inc;
    logic [DEN_W:0]       div_sh;
    logic [9:0]           rate_c;
    logic [N_W-1:0]       n_val;

    assign lanes     = lanes_of(count_reg);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // handshakes: config takes priority over requests in idle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;

    // scan progress
    assign issue     = (iss_cnt_reg != lanes);
    assign scan_done = (proc_cnt_reg == lanes);
    assign div_done  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign rd_time   = rd_bit_reg ? mem_q : '0;

    // cursor reduction compare
    assign rem_sh = (LANE_W + 1)'(cursor_reg);
    assign rem_ge = ((LANE_W + 1 > CNT_W) ? rem_sh >= (LANE_W + 1)'(lanes)
                                          : CNT_W'(cursor_reg) >= lanes);

    // rate clamp
    always_comb
    begin
        if (rate_reg < 10'(RATE_MIN))
            rate_c = 10'(RATE_MIN);
        else if (rate_reg > 10'(RATE_MAX))
            rate_c = 10'(RATE_MAX);
        else
            rate_c = rate_reg;
    end

    assign n_val = N_W'(span_reg) * N_W'(SCALED_MS);

    // divider step
    assign div_sh = {rem_reg, quot_reg[NUM_W-1]};

    // lane choice and free-time update
    assign sel_lane  = found_reg ? free_lane_reg : best_lane_reg;
    assign sel_time  = found_reg ? free_time_reg : best_reg;
    assign base_time = (now_reg > sel_time) ? now_reg : sel_time;
    assign cd_raw    = small_reg ? CD_W'(alt_reg) : quot_reg;
    assign cd        = (cd_raw == '0) ? CD_W'(1) : cd_raw;
    assign sum       = SUM_W'(base_time) + SUM_W'(cd);
    assign lane_inc  = (CNT_W'(sel_lane) + CNT_W'(1) == lanes) ? '0 : sel_lane + 1'b1;

    assign mem_we    = (state_reg == ST_UPDATE);
    assign mem_waddr = sel_lane;
    assign mem_wdata = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_acc && cfg_index == CFG_LANE_COUNT)
                    state_next = ST_CURSOR_MOD;
                else if (in_acc && in_data.func == FUNC_PLACE)
                    state_next = ST_PREP;
            end
            ST_CURSOR_MOD:
            begin
                if (!rem_ge)
                    state_next = ST_IDLE;
            end
            ST_PREP:   state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done && div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            count_reg     <= LANE_COUNT_RESET;
            rate_reg      <= RATE_Q8_RESET;
            lane_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_acc)
            begin
                if (cfg_index == CFG_LANE_COUNT)
                begin
                    count_reg <= cfg_data[6:0];
                    if (lanes_of(cfg_data[6:0]) != lanes)
                    begin
                        for (int i = 0; i < MAX_LANES; i++)
                        begin
                            if (CNT_W'(i) >= lanes_of(cfg_data[6:0]))
                                lane_vld_reg[i] <= 1'b0;
                        end
                    end
                end
                else if (cfg_index == CFG_RATE_Q8)
                begin
                    rate_reg <= cfg_data;
                end
            end

            // seek clears all lanes
            if (in_acc && in_data.func == FUNC_SEEK)
            begin
                lane_vld_reg <= '0;
                cursor_reg   <= '0;
            end

            // cursor reduced by repeated subtraction
            if (state_reg == ST_CURSOR_MOD && rem_ge)
                cursor_reg <= LANE_W'(CNT_W'(cursor_reg) - lanes);

            if (state_reg == ST_UPDATE)
            begin
                lane_vld_reg[sel_lane] <= 1'b1;
                cursor_reg             <= lane_inc;
            end

            // output register
            if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // free-time memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[iss_lane_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                now_reg   <= TIME_BITS'(in_data.now_ms);
                width_reg <= in_data.width_px;
                speed_reg <= in_data.speed_px_s;
            end
            ST_PREP:
            begin
                span_reg <= SPAN_W'(width_reg) + SPAN_W'(GAP_PX);
                d_reg    <= D_W'(speed_reg) * D_W'(rate_c);
            end
            ST_LOAD:
            begin
                // divider and scan start together
                small_reg     <= (d_reg < D_W'(Q8_ONE));
                alt_reg       <= ALT_W'(span_reg) * ALT_W'(MS_PER_S);
                den_reg       <= {d_reg, 1'b0};
                quot_reg      <= {n_val, 1'b0} + NUM_W'(d_reg);
                rem_reg       <= '0;
                div_cnt_reg   <= '0;
                iss_lane_reg  <= cursor_reg;
                iss_cnt_reg   <= '0;
                proc_cnt_reg  <= '0;
                rd_vld_reg    <= 1'b0;
                found_reg     <= 1'b0;
            end
            ST_SCAN:
            begin
                // serial restoring divide
                if (!div_done)
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_sh >= {1'b0, den_reg})
                    begin
                        rem_reg  <= DEN_W'(div_sh - {1'b0, den_reg});
                        quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= div_sh[DEN_W-1:0];
                        quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
                    end
                end

                // issue one read per cycle, wrapping at the lane count
                rd_vld_reg  <= issue;
                rd_lane_reg <= iss_lane_reg;
                rd_bit_reg  <= lane_vld_reg[iss_lane_reg];
                if (issue)
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    if (CNT_W'(iss_lane_reg) + CNT_W'(1) == lanes)
                        iss_lane_reg <= '0;
                    else
                        iss_lane_reg <= iss_lane_reg + 1'b1;
                end

                // first free lane and earliest lane
                if (rd_vld_reg)
                begin
                    proc_cnt_reg <= proc_cnt_reg + 1'b1;
                    if (!found_reg && rd_time <= now_reg)
                    begin
                        found_reg     <= 1'b1;
                        free_lane_reg <= rd_lane_reg;
                        free_time_reg <= rd_time;
                    end
                    if (proc_cnt_reg == '0 || rd_time < best_reg)
                    begin
                        best_reg      <= rd_time;
                        best_lane_reg <= rd_lane_reg;
                    end
                end
            end
            ST_UPDATE:
            begin
                res_reg.lane_index  <= 6'(sel_lane);
                res_reg.was_forced  <= !found_reg;
                res_reg.wait_ms     <= found_reg ? 40'd0 : 40'(best_reg - now_reg);
                res_reg.cooldown_ms <= 40'(cd);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    out_data_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
